FILE: rtl/oagc_pkg.sv
// Shared types and constants of the calibration-record white-balance gain calculator.
// Used by oagc_div and otp_awb_gain_calc; depends on nothing else.
package oagc_pkg;

  // Record layout: flag byte, checksum byte, then the data bytes.
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned OFF_W       = 4;
  localparam int unsigned FIRST_DATA  = 2;
  localparam logic [POS_W-1:0] LAST_POS = 5'd31;

  // Data byte indexes of the red and blue values (high byte first).
  localparam int unsigned RED_HI_IDX  = 6;
  localparam int unsigned RED_LO_IDX  = 7;
  localparam int unsigned BLUE_HI_IDX = 8;
  localparam int unsigned BLUE_LO_IDX = 9;

  localparam logic [BYTE_W-1:0] FLAG_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] FLAG_VALID = 8'h40;
  localparam logic [1:0]        HI_MASK    = 2'h3;

  // Configuration register indexes.
  localparam logic REG_GOLDEN_RED  = 1'b0;
  localparam logic REG_GOLDEN_BLUE = 1'b1;

  // Arithmetic widths.
  localparam int unsigned SUM_W   = 12;
  localparam int unsigned VAL_W   = 10;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned QUOT_W  = 32;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned NUM_W   = QUOT_W + VAL_W;
  localparam logic [GAIN_W-1:0] UNITY = 16'h0100;
  localparam logic [8:0]        MOD_BASE = 9'd255;

  // Result packing.
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned RES_W   = STAT_W + 3 * GAIN_W;
  localparam int unsigned TDATA_W = ((RES_W + 7) / 8) * 8;

  // Record selection: none, first or second record.
  localparam logic [1:0] GRP_NONE   = 2'd0;
  localparam logic [1:0] GRP_FIRST  = 2'd1;
  localparam logic [1:0] GRP_SECOND = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_CHECK_FAIL = 2'd1,
    STAT_ZERO       = 2'd2,
    STAT_SHORT      = 2'd3
  } oagc_status_e;

  // Which values fall below their golden references.
  typedef enum logic [1:0] {
    BR_BOTH_LOW,
    BR_BLUE_LOW,
    BR_RED_LOW,
    BR_BOTH_HIGH
  } oagc_branch_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHECK,
    ST_START,
    ST_WAIT,
    ST_DONE
  } oagc_state_e;

endpackage

FILE: rtl/otp_awb_gain_calc.sv
// White-balance gain calculator fed from a calibration byte load.
// Depends on oagc_pkg and instantiates the shared divider oagc_div.
//
// Use: calibration bytes enter on the s_axis stream one per request, in address
// order; s_axis_tlast marks the final byte of the load. Two 16-byte records are
// parsed on the fly (flag, checksum, data bytes), so a byte is taken every cycle.
// After the last byte the block drops s_axis_tready, checks the chosen record in
// ST_CHECK and then runs two or three divisions on one shared restoring divider,
// 42 quotient bits at one bit per cycle. A failed status skips the divisions and
// goes straight to the result; otherwise two divisions run, or three when both
// values are at or above their references.
// The result (status and three 8.8 gains) sits in an output register on m_axis;
// while the receiver stalls, the block holds it and waits with the next result,
// then clears its load state and takes bytes again.
// The user must write the golden references through cfg_we_i/cfg_idx_i/cfg_wdata_i
// only while idle; the block does not enforce it. Reset clears the load state,
// empties the output register and sets the golden references to 604 (red) and 615 (blue).
module otp_awb_gain_calc
  import oagc_pkg::*;
#(
  parameter int unsigned DATA_BYTES = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration writes.
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [VAL_W-1:0]   cfg_wdata_i,
  // Byte stream in.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [BYTE_W-1:0]  s_axis_tdata,   // otp_byte
  input  logic               s_axis_tlast,   // byte_last
  // Result stream out.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata    // status, red_gain, green_gain, blue_gain, pad
);

  localparam logic [POS_W-1:0] DATA_END  = POS_W'(FIRST_DATA + DATA_BYTES);
  localparam logic [POS_W-1:0] END_FIRST = POS_W'(1 + DATA_BYTES);
  localparam logic [POS_W-1:0] END_SECOND = POS_W'(17 + DATA_BYTES);

  // Configuration registers.
  logic [VAL_W-1:0] golden_red_q, golden_blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      golden_red_q  <= 10'd604;
      golden_blue_q <= 10'd615;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_GOLDEN_RED) begin
        golden_red_q <= cfg_wdata_i;
      end else begin
        golden_blue_q <= cfg_wdata_i;
      end
    end
  end

  oagc_state_e  state_q, state_d;
  oagc_branch_e branch_q, branch_d;
  oagc_status_e status_q, status_d;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  last_idx_q, last_idx_d;
  logic              load_full_q, load_full_d;
  logic [1:0]        chosen_q, chosen_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [BYTE_W-1:0] check_q, check_d;
  logic [VAL_W-1:0]  red_q, red_d;
  logic [VAL_W-1:0]  blue_q, blue_d;
  logic [1:0]        step_q, step_d;
  logic              pick_b_q, pick_b_d;
  logic [QUOT_W-1:0] ratio_q, ratio_d;
  logic [QUOT_W-1:0] ratio2_q, ratio2_d;
  logic [GAIN_W-1:0] gain_r_q, gain_r_d;
  logic [GAIN_W-1:0] gain_g_q, gain_g_d;
  logic [GAIN_W-1:0] gain_b_q, gain_b_d;
  logic              out_valid_q, out_valid_d;
  logic [TDATA_W-1:0] out_data_q, out_data_d;

  logic              in_acc;
  logic              out_free;
  logic [OFF_W-1:0]  off;
  logic [1:0]        rec_grp;
  logic [1:0]        chosen_take;

  // Checksum and status evaluation.
  logic [8:0]        mod_t;
  logic [8:0]        mod_r;
  logic [8:0]        chk_sum;
  logic [POS_W-1:0]  rec_end;
  oagc_status_e      status_eval;

  // Divider operand selection.
  logic              div_start;
  logic              div_done;
  logic [QUOT_W-1:0] div_quot;
  logic [NUM_W-1:0]  div_num;
  logic [VAL_W-1:0]  div_den;
  logic              use_prod;
  logic [VAL_W-1:0]  shift_src;
  logic [QUOT_W-1:0] mul_a;
  logic [VAL_W-1:0]  mul_b;
  logic [NUM_W-1:0]  product;
  logic              finish;

  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign off           = pos_q[OFF_W-1:0];
  assign rec_grp       = pos_q[POS_W-1] ? GRP_SECOND : GRP_FIRST;

  // The sum reduced mod 255: 256 is one mod 255, so fold the high nibble in.
  assign mod_t   = {5'd0, sum_q[SUM_W-1:BYTE_W]} + {1'b0, sum_q[BYTE_W-1:0]};
  assign mod_r   = (mod_t >= MOD_BASE) ? (mod_t - MOD_BASE) : mod_t;
  assign chk_sum = mod_r + 9'd1;
  assign rec_end = (chosen_q == GRP_FIRST) ? END_FIRST : END_SECOND;

  always_comb begin
    status_eval = STAT_OK;
    if (chosen_q == GRP_NONE) begin
      status_eval = (last_idx_q < 5'd16) ? STAT_SHORT : STAT_CHECK_FAIL;
    end else if (last_idx_q < rec_end) begin
      status_eval = STAT_SHORT;
    end else if (chk_sum != {1'b0, check_q}) begin
      status_eval = STAT_CHECK_FAIL;
    end else if (red_q == '0 || blue_q == '0) begin
      status_eval = STAT_ZERO;
    end
  end

  // Divider operands for each branch and step.
  always_comb begin
    use_prod  = 1'b0;
    shift_src = blue_q;
    div_den   = golden_blue_q;
    mul_a     = {16'd0, ratio_q[GAIN_W-1:0]};
    mul_b     = golden_blue_q;
    case (branch_q)
      BR_BOTH_LOW: begin
        if (step_q == 2'd0) begin
          shift_src = golden_blue_q;
          div_den   = blue_q;
        end else begin
          shift_src = golden_red_q;
          div_den   = red_q;
        end
      end
      BR_BLUE_LOW: begin
        if (step_q == 2'd0) begin
          shift_src = red_q;
          div_den   = golden_red_q;
        end else begin
          use_prod = 1'b1;
          mul_b    = golden_blue_q;
          div_den  = blue_q;
        end
      end
      BR_RED_LOW: begin
        if (step_q == 2'd0) begin
          shift_src = blue_q;
          div_den   = golden_blue_q;
        end else begin
          use_prod = 1'b1;
          mul_b    = golden_red_q;
          div_den  = red_q;
        end
      end
      default: begin
        if (step_q == 2'd0) begin
          shift_src = blue_q;
          div_den   = golden_blue_q;
        end else if (step_q == 2'd1) begin
          shift_src = red_q;
          div_den   = golden_red_q;
        end else begin
          use_prod = 1'b1;
          if (pick_b_q) begin
            mul_a   = ratio_q;
            mul_b   = golden_red_q;
            div_den = red_q;
          end else begin
            mul_a   = ratio2_q;
            mul_b   = golden_blue_q;
            div_den = blue_q;
          end
        end
      end
    endcase
  end

  // The product lands in the divider's numerator register.
  assign product = NUM_W'(mul_a) * NUM_W'(mul_b);
  assign div_num = use_prod ? product
                            : {{(NUM_W - VAL_W - FRAC_W){1'b0}}, shift_src, {FRAC_W{1'b0}}};
  assign div_start = (state_q == ST_START);

  oagc_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (VAL_W),
    .QUOT_W (QUOT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Sequencer, byte parsing and result hand-off.
  always_comb begin
    state_d     = state_q;
    branch_d    = branch_q;
    status_d    = status_q;
    pos_d       = pos_q;
    last_idx_d  = last_idx_q;
    load_full_d = load_full_q;
    chosen_d    = chosen_q;
    sum_d       = sum_q;
    check_d     = check_q;
    red_d       = red_q;
    blue_d      = blue_q;
    step_d      = step_q;
    pick_b_d    = pick_b_q;
    ratio_d     = ratio_q;
    ratio2_d    = ratio2_q;
    gain_r_d    = gain_r_q;
    gain_g_d    = gain_g_q;
    gain_b_d    = gain_b_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    chosen_take = chosen_q;
    finish      = 1'b0;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (!load_full_q) begin
            // Pick the first record whose flag top bits are 01.
            if (off == '0 && chosen_q == GRP_NONE &&
                (s_axis_tdata & FLAG_MASK) == FLAG_VALID) begin
              chosen_take = rec_grp;
            end
            chosen_d = chosen_take;
            if (chosen_take == rec_grp) begin
              if (off == OFF_W'(1)) begin
                check_d = s_axis_tdata;
              end else if (off >= OFF_W'(FIRST_DATA) && {1'b0, off} < DATA_END) begin
                sum_d = sum_q + {{(SUM_W - BYTE_W){1'b0}}, s_axis_tdata};
                if (off == OFF_W'(FIRST_DATA + RED_HI_IDX)) begin
                  red_d[VAL_W-1:BYTE_W] = s_axis_tdata[1:0] & HI_MASK;
                end else if (off == OFF_W'(FIRST_DATA + RED_LO_IDX)) begin
                  red_d[BYTE_W-1:0] = s_axis_tdata;
                end else if (off == OFF_W'(FIRST_DATA + BLUE_HI_IDX)) begin
                  blue_d[VAL_W-1:BYTE_W] = s_axis_tdata[1:0] & HI_MASK;
                end else if (off == OFF_W'(FIRST_DATA + BLUE_LO_IDX)) begin
                  blue_d[BYTE_W-1:0] = s_axis_tdata;
                end
              end
            end
            if (pos_q == LAST_POS) begin
              load_full_d = 1'b1;
            end else begin
              pos_d = pos_q + 1'b1;
            end
          end
          last_idx_d = pos_q;
          if (s_axis_tlast) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        status_d = status_eval;
        step_d   = 2'd0;
        gain_r_d = UNITY;
        gain_g_d = UNITY;
        gain_b_d = UNITY;
        if (blue_q < golden_blue_q) begin
          branch_d = (red_q < golden_red_q) ? BR_BOTH_LOW : BR_BLUE_LOW;
        end else begin
          branch_d = (red_q < golden_red_q) ? BR_RED_LOW : BR_BOTH_HIGH;
        end
        state_d = (status_eval == STAT_OK) ? ST_START : ST_DONE;
      end
      ST_START: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          case (branch_q)
            BR_BOTH_LOW: begin
              if (step_q == 2'd0) begin
                gain_b_d = div_quot[GAIN_W-1:0];
              end else begin
                gain_r_d = div_quot[GAIN_W-1:0];
                finish   = 1'b1;
              end
            end
            BR_BLUE_LOW: begin
              if (step_q == 2'd0) begin
                gain_g_d = div_quot[GAIN_W-1:0];
                ratio_d  = div_quot;
              end else begin
                gain_b_d = div_quot[GAIN_W-1:0];
                finish   = 1'b1;
              end
            end
            BR_RED_LOW: begin
              if (step_q == 2'd0) begin
                gain_g_d = div_quot[GAIN_W-1:0];
                ratio_d  = div_quot;
              end else begin
                gain_r_d = div_quot[GAIN_W-1:0];
                finish   = 1'b1;
              end
            end
            default: begin
              if (step_q == 2'd0) begin
                ratio_d = div_quot;
              end else if (step_q == 2'd1) begin
                ratio2_d = div_quot;
                pick_b_d = (ratio_q > div_quot);
              end else begin
                // The larger ratio sets green; its channel stays at unity.
                if (pick_b_q) begin
                  gain_g_d = ratio_q[GAIN_W-1:0];
                  gain_r_d = div_quot[GAIN_W-1:0];
                end else begin
                  gain_g_d = ratio2_q[GAIN_W-1:0];
                  gain_b_d = div_quot[GAIN_W-1:0];
                end
                finish = 1'b1;
              end
            end
          endcase
          step_d  = step_q + 1'b1;
          state_d = finish ? ST_DONE : ST_START;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (status_q == STAT_OK) begin
            out_data_d = {{(TDATA_W - RES_W){1'b0}}, gain_b_q, gain_g_q, gain_r_q, status_q};
          end else begin
            out_data_d = {{(TDATA_W - STAT_W){1'b0}}, status_q};
          end
          // Load state returns to reset once the result enters the output register.
          pos_d       = '0;
          last_idx_d  = '0;
          load_full_d = 1'b0;
          chosen_d    = GRP_NONE;
          sum_d       = '0;
          check_d     = '0;
          red_d       = '0;
          blue_d      = '0;
          state_d     = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Control and load state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      branch_q    <= BR_BOTH_LOW;
      status_q    <= STAT_OK;
      pos_q       <= '0;
      last_idx_q  <= '0;
      load_full_q <= 1'b0;
      chosen_q    <= GRP_NONE;
      sum_q       <= '0;
      check_q     <= '0;
      red_q       <= '0;
      blue_q      <= '0;
      step_q      <= '0;
      pick_b_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      branch_q    <= branch_d;
      status_q    <= status_d;
      pos_q       <= pos_d;
      last_idx_q  <= last_idx_d;
      load_full_q <= load_full_d;
      chosen_q    <= chosen_d;
      sum_q       <= sum_d;
      check_q     <= check_d;
      red_q       <= red_d;
      blue_q      <= blue_d;
      step_q      <= step_d;
      pick_b_q    <= pick_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Gain datapath and result payload.
  always_ff @(posedge clk_i) begin
    ratio_q    <= ratio_d;
    ratio2_q   <= ratio2_d;
    gain_r_q   <= gain_r_d;
    gain_g_q   <= gain_g_d;
    gain_b_q   <= gain_b_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A failed result never carries gains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[STAT_W-1:0] != STAT_OK))
      |-> (m_axis_tdata[TDATA_W-1:STAT_W] == '0))
    else $error("failed result carries nonzero gains");

  // Once the load is full the byte position rests on the last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_full_q |-> (pos_q == LAST_POS))
    else $error("load full with byte position off the last byte");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_WAIT))
    else $error("divider finished outside the wait state");

  // Only the two records can be chosen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chosen_q == GRP_NONE) || (chosen_q == GRP_FIRST) || (chosen_q == GRP_SECOND))
    else $error("invalid record selection");

endmodule

FILE: rtl/oagc_div.sv
// Iterative restoring divider, one quotient bit per cycle, for the gain calculator.
// Imports oagc_pkg but uses nothing from it; self-contained arithmetic.
module oagc_div
  import oagc_pkg::*;
#(
  parameter int unsigned NUM_W  = 42,
  parameter int unsigned DEN_W  = 10,
  parameter int unsigned QUOT_W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic              done_o,
  output logic [QUOT_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [QUOT_W-1:0] quot_q, quot_d;

  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_diff;
  logic              rem_ge;

  // One restoring step: shift in the next numerator bit, subtract if it fits.
  // A zero divisor always fits, so the quotient comes out all ones.
  assign rem_sh   = {rem_q, num_q[NUM_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, den_q});
  assign rem_diff = rem_sh - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W - 1);
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quot_d = '0;
    end else if (busy_q) begin
      num_d  = {num_q[NUM_W-2:0], 1'b0};
      rem_d  = rem_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quot_d = {quot_q[QUOT_W-2:0], rem_ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
